>>> src/rpp_pkg.sv
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int MAX_BITS_DEF  = 16;
  localparam int INT_W         = 10;
  localparam int PIX_W         = 32;
  localparam int HALF_W        = 16;
  localparam int POS_W         = 5;
  localparam int BIDX_W        = 4;
  localparam int COMP_W        = 2;
  localparam int CFG_BITS_W    = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int PERMILLE_FULL = 1000;

  localparam logic [CFG_BITS_W-1:0] RED_BITS_RST   = CFG_BITS_W'(5);
  localparam logic [CFG_BITS_W-1:0] GREEN_BITS_RST = CFG_BITS_W'(6);
  localparam logic [CFG_BITS_W-1:0] BLUE_BITS_RST  = CFG_BITS_W'(5);
  localparam logic                  MODE16_RST     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_BITS         = 2'd0,
    REG_GREEN_BITS       = 2'd1,
    REG_BLUE_BITS        = 2'd2,
    REG_SIXTEEN_BIT_MODE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  localparam logic [COMP_W-1:0] COMP_RED   = 2'd0;
  localparam logic [COMP_W-1:0] COMP_GREEN = 2'd1;
  localparam logic [COMP_W-1:0] COMP_BLUE  = 2'd2;

  // per-lane stage enables and map write strobe
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
    logic map_we;
  } lane_ctrl_t;

endpackage

>>> src/rpp_lane.sv
`timescale 1ns / 1ps

module rpp_lane #(
  parameter int MAX_COMPONENT_BITS = rpp_pkg::MAX_BITS_DEF
) (
  input  logic                           clk,
  input  rpp_pkg::lane_ctrl_t            ctrl,
  input  logic [rpp_pkg::INT_W-1:0]      intensity,
  input  logic [rpp_pkg::CFG_BITS_W-1:0] bits,
  input  logic [rpp_pkg::BIDX_W-1:0]     wr_idx,
  input  logic [rpp_pkg::POS_W-1:0]      wr_pos,
  output logic [rpp_pkg::PIX_W-1:0]      pattern
);
  import rpp_pkg::*;

  localparam int IDX_W  = (MAX_COMPONENT_BITS > 1) ? $clog2(MAX_COMPONENT_BITS) : 1;
  localparam int P_W    = INT_W + MAX_COMPONENT_BITS;
  localparam int RECIP  = (2 ** P_W) / PERMILLE_FULL;
  localparam int R_W    = $clog2(RECIP + 1);
  localparam int PROD_W = P_W + R_W;
  localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);

  logic [INT_W-1:0]              level;
  logic [CFG_BITS_W-1:0]         bits_sat;
  logic [P_W-1:0]                p_next;
  logic [P_W-1:0]                p1;
  logic [P_W-1:0]                p2;
  logic [PROD_W-1:0]             prod;
  logic [MAX_COMPONENT_BITS-1:0] qe2;
  logic [P_W-1:0]                back;
  logic [P_W-1:0]                rem;
  logic [MAX_COMPONENT_BITS-1:0] q_next;
  logic [MAX_COMPONENT_BITS-1:0] q3;
  logic [POS_W-1:0]              map [MAX_COMPONENT_BITS];

  // (2^bits - 1) * level as a shift and subtract
  always_comb begin
    level    = (intensity > INT_W'(PERMILLE_FULL)) ? INT_W'(PERMILLE_FULL) : intensity;
    bits_sat = (bits > CFG_BITS_W'(MAX_COMPONENT_BITS)) ?
               CFG_BITS_W'(MAX_COMPONENT_BITS) : bits;
    p_next   = (P_W'(level) << bits_sat) - P_W'(level);
  end

  // reciprocal estimate is exact or one short
  assign prod = PROD_W'(p1) * PROD_W'(RECIP_V);

  always_comb begin
    back   = P_W'(qe2) * P_W'(PERMILLE_FULL);
    rem    = p2 - back;
    q_next = qe2 + MAX_COMPONENT_BITS'(rem >= P_W'(PERMILLE_FULL));
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      p1 <= p_next;
    end
    if (ctrl.adv2) begin
      p2  <= p1;
      qe2 <= prod[P_W +: MAX_COMPONENT_BITS];
    end
    if (ctrl.adv3) begin
      q3 <= q_next;
    end
    if (ctrl.map_we) begin
      map[wr_idx[IDX_W-1:0]] <= wr_pos;
    end
  end

  always_comb begin
    pattern = '0;
    for (int b = 0; b < MAX_COMPONENT_BITS; b++) begin
      if (q3[b]) begin
        pattern = pattern | (PIX_W'(1) << map[b]);
      end
    end
  end

endmodule

>>> src/rpp_merge.sv
`timescale 1ns / 1ps

module rpp_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [rpp_pkg::PIX_W-1:0] pat_red,
  input  logic [rpp_pkg::PIX_W-1:0] pat_green,
  input  logic [rpp_pkg::PIX_W-1:0] pat_blue,
  input  logic                      sixteen_bit_mode,
  input  logic                      pixel_ready,
  output logic                      pixel_valid,
  output logic [rpp_pkg::PIX_W-1:0] pixel_value,
  output logic                      space
);
  import rpp_pkg::*;

  logic [PIX_W-1:0] merged;
  logic [PIX_W-1:0] pixel_next;

  always_comb begin
    merged     = pat_red | pat_green | pat_blue;
    pixel_next = sixteen_bit_mode ? PIX_W'(merged[HALF_W-1:0]) : merged;
  end

  assign space = !pixel_valid || pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (space) begin
      pixel_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      pixel_value <= pixel_next;
    end
  end

endmodule

>>> src/rgb_permille_to_pixel_packer_unit.sv
`timescale 1ns / 1ps

// Per-mille RGB to direct-colour pixel packer.
// item channel (item_valid/item_ready): command 1 converts the three
// intensities, command 0 loads one bit position map entry and gives no beat
// on the pixel channel. pixel channel (pixel_valid/pixel_ready) carries the
// packed pixel_value. cfg channel (cfg_valid/cfg_ready, always ready) writes
// red_bits, green_bits, blue_bits and sixteen_bit_mode; write it only while
// no item is in flight.
// Three component lanes each run a three-stage pipe: shift-subtract scale,
// reciprocal multiply for the divide by 1000, one correction step; the map
// scatter and the OR of the lanes feed the output register.
// A convert item passes the pipe stages and then the output register.
// Throughput: one item per cycle unless pixel_ready stalls. A stalled
// pixel channel holds its beat in the output register while the pipe
// keeps filling; item_ready falls only once all stages are occupied.
// Reset clears the pipe valids and the output valid and restores the
// registers to 5/6/5 bits, sixteen-bit mode. The map is not cleared: load
// every entry before a conversion uses it.
module rgb_permille_to_pixel_packer_unit #(
  parameter int MAX_COMPONENT_BITS = rpp_pkg::MAX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           command,
  input  logic [rpp_pkg::COMP_W-1:0]     component,
  input  logic [rpp_pkg::BIDX_W-1:0]     bit_index,
  input  logic [rpp_pkg::POS_W-1:0]      bit_position,
  input  logic [rpp_pkg::INT_W-1:0]      red_intensity,
  input  logic [rpp_pkg::INT_W-1:0]      green_intensity,
  input  logic [rpp_pkg::INT_W-1:0]      blue_intensity,
  output logic                           pixel_valid,
  input  logic                           pixel_ready,
  output logic [rpp_pkg::PIX_W-1:0]      pixel_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpp_pkg::CFG_BITS_W-1:0] cfg_data
);
  import rpp_pkg::*;

  logic [CFG_BITS_W-1:0] red_bits;
  logic [CFG_BITS_W-1:0] green_bits;
  logic [CFG_BITS_W-1:0] blue_bits;
  logic                  sixteen_bit_mode;

  logic v1, v2, v3;
  cmd_t cmd1, cmd2, cmd3;
  logic [COMP_W-1:0] comp1, comp2, comp3;
  logic [BIDX_W-1:0] idx1, idx2, idx3;
  logic [POS_W-1:0]  pos1, pos2, pos3;
  logic idx_ok1, idx_ok2, idx_ok3;

  logic ready1, ready2, ready3;
  logic adv1, adv2, adv3;
  logic space;
  logic push;
  logic load3;
  logic we_red, we_green, we_blue;

  lane_ctrl_t ctrl_red, ctrl_green, ctrl_blue;
  logic [PIX_W-1:0] pat_red, pat_green, pat_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_bits         <= RED_BITS_RST;
      green_bits       <= GREEN_BITS_RST;
      blue_bits        <= BLUE_BITS_RST;
      sixteen_bit_mode <= MODE16_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED_BITS:         red_bits         <= cfg_data;
        REG_GREEN_BITS:       green_bits       <= cfg_data;
        REG_BLUE_BITS:        blue_bits        <= cfg_data;
        REG_SIXTEEN_BIT_MODE: sixteen_bit_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // loads retire in stage 3 without touching the output
  assign load3  = (cmd3 == CMD_LOAD);
  assign ready3 = !v3 || load3 || space;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign item_ready = ready1;

  assign adv1 = ready1 && item_valid;
  assign adv2 = ready2 && v1;
  assign adv3 = ready3 && v2;

  assign push = v3 && (cmd3 == CMD_CONVERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= item_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      cmd1    <= cmd_t'(command);
      comp1   <= component;
      idx1    <= bit_index;
      pos1    <= bit_position;
      idx_ok1 <= ({1'b0, bit_index} < (BIDX_W + 1)'(MAX_COMPONENT_BITS));
    end
    if (adv2) begin
      cmd2    <= cmd1;
      comp2   <= comp1;
      idx2    <= idx1;
      pos2    <= pos1;
      idx_ok2 <= idx_ok1;
    end
    if (adv3) begin
      cmd3    <= cmd2;
      comp3   <= comp2;
      idx3    <= idx2;
      pos3    <= pos2;
      idx_ok3 <= idx_ok2;
    end
  end

  assign we_red   = v3 && load3 && idx_ok3 && (comp3 == COMP_RED);
  assign we_green = v3 && load3 && idx_ok3 && (comp3 == COMP_GREEN);
  assign we_blue  = v3 && load3 && idx_ok3 && (comp3 == COMP_BLUE);

  assign ctrl_red   = '{adv1: adv1, adv2: adv2, adv3: adv3, map_we: we_red};
  assign ctrl_green = '{adv1: adv1, adv2: adv2, adv3: adv3, map_we: we_green};
  assign ctrl_blue  = '{adv1: adv1, adv2: adv2, adv3: adv3, map_we: we_blue};

  rpp_lane #(.MAX_COMPONENT_BITS(MAX_COMPONENT_BITS)) u_lane_red (
    .clk       (clk),
    .ctrl      (ctrl_red),
    .intensity (red_intensity),
    .bits      (red_bits),
    .wr_idx    (idx3),
    .wr_pos    (pos3),
    .pattern   (pat_red)
  );

  rpp_lane #(.MAX_COMPONENT_BITS(MAX_COMPONENT_BITS)) u_lane_green (
    .clk       (clk),
    .ctrl      (ctrl_green),
    .intensity (green_intensity),
    .bits      (green_bits),
    .wr_idx    (idx3),
    .wr_pos    (pos3),
    .pattern   (pat_green)
  );

  rpp_lane #(.MAX_COMPONENT_BITS(MAX_COMPONENT_BITS)) u_lane_blue (
    .clk       (clk),
    .ctrl      (ctrl_blue),
    .intensity (blue_intensity),
    .bits      (blue_bits),
    .wr_idx    (idx3),
    .wr_pos    (pos3),
    .pattern   (pat_blue)
  );

  rpp_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .pat_red          (pat_red),
    .pat_green        (pat_green),
    .pat_blue         (pat_blue),
    .sixteen_bit_mode (sixteen_bit_mode),
    .pixel_ready      (pixel_ready),
    .pixel_valid      (pixel_valid),
    .pixel_value      (pixel_value),
    .space            (space)
  );

`ifndef SYNTH
  a_one_map_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({we_red, we_green, we_blue}))
    else $error("more than one lane map written in one cycle");

  a_pixel_from_convert: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(v3 && (cmd3 == CMD_CONVERT)))
    else $error("pixel beat without a convert in the last stage");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !load3 && pixel_valid && !pixel_ready) |-> !item_ready)
    else $error("item taken while every stage is held");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ready3) |=> (v3 && $stable(cmd3)))
    else $error("stalled convert left the last stage");

  a_load_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (v3 && load3 && !pixel_valid) |=> !pixel_valid)
    else $error("load produced a pixel beat");
`endif

endmodule
